@@ sv/ltcc_pkg.sv @@
// Shared types and constants for the link table cycle classifier.
package ltcc_pkg;

   // Width and span of the node index fields on the request item.
   localparam int REQ_NODE_W    = 6;
   localparam int REQ_NODE_SPAN = 64;
   localparam int WEIGHT_W      = 16;
   localparam int SLOT_W        = 8;

   // Request item: one proposed link.
   typedef struct packed {
      logic                       clear_first;
      logic [REQ_NODE_W-1:0]      from_node;
      logic [REQ_NODE_W-1:0]      to_node;
      logic signed [WEIGHT_W-1:0] link_weight;
   } req_item_type;

   // Response item: class and placement of the link.
   typedef struct packed {
      logic              is_recurrent;
      logic [SLOT_W-1:0] slot_index;
      logic              dropped;
   } rsp_item_type;

   // Per-cycle commands from the controller to the link chain.
   typedef struct packed {
      logic rotate;
      logic append;
   } chain_ctrl_type;

   // Controller states.
   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_SCAN,
      CTL_FINISH
   } ctl_state_type;

endpackage

@@ sv/ltcc_link_cell.sv @@
// One cell of the link chain: holds a single stored link.
module ltcc_link_cell import ltcc_pkg::*; #(
   parameter int NODE_W  = 6,
   parameter int COUNT_W = 9,
   parameter int INDEX   = 0
) (
   input  logic                       clock,
   input  chain_ctrl_type             ctrl,
   input  logic [COUNT_W-1:0]         count,
   input  logic [NODE_W-1:0]          head_origin,
   input  logic [NODE_W-1:0]          head_dest,
   input  logic                       head_rec,
   input  logic signed [WEIGHT_W-1:0] head_weight,
   input  logic [NODE_W-1:0]          next_origin,
   input  logic [NODE_W-1:0]          next_dest,
   input  logic                       next_rec,
   input  logic signed [WEIGHT_W-1:0] next_weight,
   input  logic [NODE_W-1:0]          new_origin,
   input  logic [NODE_W-1:0]          new_dest,
   input  logic                       new_rec,
   input  logic signed [WEIGHT_W-1:0] new_weight,
   output logic [NODE_W-1:0]          origin,
   output logic [NODE_W-1:0]          dest,
   output logic                       rec,
   output logic signed [WEIGHT_W-1:0] weight
);

   logic                       is_tail;
   logic                       is_slot;
   logic [NODE_W-1:0]          origin_ff, origin_in;
   logic [NODE_W-1:0]          dest_ff, dest_in;
   logic                       rec_ff, rec_in;
   logic signed [WEIGHT_W-1:0] weight_ff, weight_in;

   // This cell closes the ring when it holds the last stored link,
   // and takes a new link when it is the first free slot.
   assign is_tail = (count == COUNT_W'(INDEX + 1));
   assign is_slot = (count == COUNT_W'(INDEX));

   // Load a new link, or take the neighbour's link while the ring turns.
   always_comb begin
      origin_in = origin_ff;
      dest_in   = dest_ff;
      rec_in    = rec_ff;
      weight_in = weight_ff;
      if (ctrl.append && is_slot) begin
         origin_in = new_origin;
         dest_in   = new_dest;
         rec_in    = new_rec;
         weight_in = new_weight;
      end else if (ctrl.rotate) begin
         if (is_tail) begin
            origin_in = head_origin;
            dest_in   = head_dest;
            rec_in    = head_rec;
            weight_in = head_weight;
         end else begin
            origin_in = next_origin;
            dest_in   = next_dest;
            rec_in    = next_rec;
            weight_in = next_weight;
         end
      end
   end

   // Link payload needs no reset.
   always_ff @(posedge clock) begin
      origin_ff <= origin_in;
      dest_ff   <= dest_in;
      rec_ff    <= rec_in;
      weight_ff <= weight_in;
   end

   assign origin = origin_ff;
   assign dest   = dest_ff;
   assign rec    = rec_ff;
   assign weight = weight_ff;

endmodule

@@ sv/ltcc_link_chain.sv @@
// Row of link cells forming a ring over the stored links, read at its head.
module ltcc_link_chain import ltcc_pkg::*; #(
   parameter int NODE_W     = 6,
   parameter int COUNT_W    = 9,
   parameter int LINK_DEPTH = 256
) (
   input  logic                       clock,
   input  chain_ctrl_type             ctrl,
   input  logic [COUNT_W-1:0]         count,
   input  logic [NODE_W-1:0]          new_origin,
   input  logic [NODE_W-1:0]          new_dest,
   input  logic                       new_rec,
   input  logic signed [WEIGHT_W-1:0] new_weight,
   output logic [NODE_W-1:0]          head_origin,
   output logic [NODE_W-1:0]          head_dest,
   output logic                       head_rec
);

   logic [NODE_W-1:0]          cell_origin [LINK_DEPTH];
   logic [NODE_W-1:0]          cell_dest   [LINK_DEPTH];
   logic                       cell_rec    [LINK_DEPTH];
   logic signed [WEIGHT_W-1:0] cell_weight [LINK_DEPTH];

   // Each cell takes from its right-hand neighbour; the last one wraps to the head.
   for (genvar i = 0; i < LINK_DEPTH; i++) begin : g_cell
      localparam int NEXT = (i == LINK_DEPTH - 1) ? 0 : i + 1;
      ltcc_link_cell #(
         .NODE_W  (NODE_W),
         .COUNT_W (COUNT_W),
         .INDEX   (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count       (count),
         .head_origin (cell_origin[0]),
         .head_dest   (cell_dest[0]),
         .head_rec    (cell_rec[0]),
         .head_weight (cell_weight[0]),
         .next_origin (cell_origin[NEXT]),
         .next_dest   (cell_dest[NEXT]),
         .next_rec    (cell_rec[NEXT]),
         .next_weight (cell_weight[NEXT]),
         .new_origin  (new_origin),
         .new_dest    (new_dest),
         .new_rec     (new_rec),
         .new_weight  (new_weight),
         .origin      (cell_origin[i]),
         .dest        (cell_dest[i]),
         .rec         (cell_rec[i]),
         .weight      (cell_weight[i])
      );
   end

   assign head_origin = cell_origin[0];
   assign head_dest   = cell_dest[0];
   assign head_rec    = cell_rec[0];

endmodule

@@ sv/link_table_cycle_classifier_top.sv @@
// Top level of the link table cycle classifier: controller, reach mask and link chain.
//
// An item proposes a link from_node -> to_node and is accepted when start is high
// and busy is low; clear_first empties the table before the link is handled.
// The stored links sit in a ring of cells that turns by one link each cycle while
// scanning; the link at the head is tested against a reach mask seeded with to_node.
// A pass visits each stored link once, and passes repeat until a pass adds no node.
// After the passes a finishing state classifies and appends the link, and
// the result appears on rsp_item with rsp_strobe high for one cycle after that.
// The number of passes is none after a clear or with an empty table, otherwise at
// least one and at most NODE_COUNT.
// busy is high from the accepting edge until the finishing cycle has ended.
// A full table drops the link, reports slot 0 and sets dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset empties the table and returns the controller to idle at once.
module link_table_cycle_classifier_top import ltcc_pkg::*; #(
   parameter int NODE_COUNT = 64,
   parameter int LINK_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   localparam int NODE_W  = $clog2(NODE_COUNT);
   localparam int STEP_W  = $clog2(LINK_DEPTH);
   localparam int COUNT_W = $clog2(LINK_DEPTH + 1);

   ctl_state_type              state_ff, state_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       grew_ff, grew_in;
   logic [NODE_COUNT-1:0]      mask_ff, mask_in;
   logic [NODE_W-1:0]          origin_ff, origin_in;
   logic [NODE_W-1:0]          dest_ff, dest_in;
   logic signed [WEIGHT_W-1:0] weight_ff, weight_in;
   logic                       rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type               rsp_item_ff, rsp_item_in;

   logic [NODE_W-1:0]          node_tab [REQ_NODE_SPAN];
   logic [NODE_W-1:0]          req_origin;
   logic [NODE_W-1:0]          req_dest;
   logic                       accept;
   logic [NODE_W-1:0]          head_origin;
   logic [NODE_W-1:0]          head_dest;
   logic                       head_rec;
   logic                       hit;
   logic                       last_step;
   logic                       full;
   logic                       rec;
   logic [STEP_W+SLOT_W-1:0]   slot_wide;
   chain_ctrl_type             chain_ctrl;

   // Constant table reducing a request node index modulo the node count.
   for (genvar v = 0; v < REQ_NODE_SPAN; v++) begin : g_node_tab
      assign node_tab[v] = NODE_W'(v % NODE_COUNT);
   end

   assign req_origin = node_tab[req_item.from_node];
   assign req_dest   = node_tab[req_item.to_node];
   assign accept     = start && (state_ff == CTL_IDLE);

   // Head link test: a normal link leaving a reached node towards a new one.
   assign hit       = !head_rec && mask_ff[head_origin] && !mask_ff[head_dest];
   assign last_step = (step_ff == STEP_W'(count_ff - 1'b1));
   assign full      = (count_ff == COUNT_W'(LINK_DEPTH));
   assign rec       = mask_ff[origin_ff];
   assign slot_wide = {{SLOT_W{1'b0}}, count_ff[STEP_W-1:0]};

   // Next state, mask update and chain commands.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      grew_in       = grew_ff;
      mask_in       = mask_ff;
      origin_in     = origin_ff;
      dest_in       = dest_ff;
      weight_in     = weight_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      chain_ctrl    = '{rotate: 1'b0, append: 1'b0};
      case (state_ff)
         CTL_IDLE: begin
            if (accept) begin
               origin_in         = req_origin;
               dest_in           = req_dest;
               weight_in         = req_item.link_weight;
               mask_in           = '0;
               mask_in[req_dest] = 1'b1;
               step_in           = '0;
               grew_in           = 1'b0;
               if (req_item.clear_first) begin
                  count_in = '0;
               end
               if (req_item.clear_first || count_ff == '0) begin
                  state_in = CTL_FINISH;
               end else begin
                  state_in = CTL_SCAN;
               end
            end
         end
         CTL_SCAN: begin
            chain_ctrl.rotate = 1'b1;
            if (hit) begin
               mask_in[head_dest] = 1'b1;
            end
            if (last_step) begin
               step_in = '0;
               grew_in = 1'b0;
               if (!(grew_ff || hit)) begin
                  state_in = CTL_FINISH;
               end
            end else begin
               step_in = step_ff + 1'b1;
               grew_in = grew_ff || hit;
            end
         end
         CTL_FINISH: begin
            rsp_strobe_in            = 1'b1;
            rsp_item_in.is_recurrent = rec;
            rsp_item_in.dropped      = full;
            if (full) begin
               rsp_item_in.slot_index = '0;
            end else begin
               rsp_item_in.slot_index = slot_wide[SLOT_W-1:0];
               chain_ctrl.append      = 1'b1;
               count_in               = count_ff + 1'b1;
            end
            state_in = CTL_IDLE;
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CTL_IDLE;
         count_ff      <= '0;
         step_ff       <= '0;
         grew_ff       <= 1'b0;
         mask_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         step_ff       <= step_in;
         grew_ff       <= grew_in;
         mask_ff       <= mask_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Item payload registers.
   always_ff @(posedge clock) begin
      origin_ff   <= origin_in;
      dest_ff     <= dest_in;
      weight_ff   <= weight_in;
      rsp_item_ff <= rsp_item_in;
   end

   // Stored links.
   ltcc_link_chain #(
      .NODE_W     (NODE_W),
      .COUNT_W    (COUNT_W),
      .LINK_DEPTH (LINK_DEPTH)
   ) u_chain (
      .clock       (clock),
      .ctrl        (chain_ctrl),
      .count       (count_ff),
      .new_origin  (origin_ff),
      .new_dest    (dest_ff),
      .new_rec     (rec),
      .new_weight  (weight_ff),
      .head_origin (head_origin),
      .head_dest   (head_dest),
      .head_rec    (head_rec)
   );

   assign busy       = (state_ff != CTL_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule
